@@ src/piecewise_linear_calibration_lookup_top_defines.svh @@
// Assertion macros for the calibration lookup block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef PIECEWISE_LINEAR_CALIBRATION_LOOKUP_TOP_DEFINES_SVH
`define PIECEWISE_LINEAR_CALIBRATION_LOOKUP_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

`define PLC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plc: implication check failed");

`define PLC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plc: next-cycle check failed");

`else

`define PLC_ASSERT_IMPLY(label, ante, cons)

`define PLC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ src/plc_pkg.sv @@
// Shared types and constants for the calibration lookup block.
// No dependencies; used by every module of the block.
package plc_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int CFG_W   = 5;
    localparam int EIDX_W  = 4;
    localparam int KEY_W   = 16;
    localparam int VAL_W   = 16;
    localparam int OUT_W   = 21;
    localparam int STAT_W  = 2;

    // product of two 17-bit signed differences
    localparam int DIV_W       = 2 * (KEY_W + 1);
    localparam int DIV_STEPS   = DIV_W / 2;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
    localparam int SUM_W       = DIV_W + 2;

    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam logic [STAT_W-1:0] STATUS_OK    = STAT_W'(0);
    localparam logic [STAT_W-1:0] STATUS_FEW   = STAT_W'(1);
    localparam logic [STAT_W-1:0] STATUS_EQUAL = STAT_W'(2);

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef struct packed {
        op_t              op;
        logic             wr_en;
        logic [IDX_W-1:0] addr;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [KEY_W-1:0] query;
        logic [CNT_W-1:0] count;
    } item_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [KEY_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
        logic [KEY_W-1:0] rem;
    } div_rsp_t;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_READ,
        BS_CMP,
        BS_CALC,
        BS_MUL,
        BS_DIVS,
        BS_DIVW,
        BS_ROUND1,
        BS_ROUND2,
        BS_OUT
    } back_state_t;

endpackage

@@ src/plc_front.sv @@
// Front end: accepts requests, classifies them and queues them for the back end.
// Holds the entries_in_use register. Depends on plc_pkg.
module plc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic [plc_pkg::EIDX_W-1:0]    entry_index,
    input  logic [plc_pkg::KEY_W-1:0]     entry_key,
    input  logic [plc_pkg::VAL_W-1:0]     entry_value,
    input  logic [plc_pkg::KEY_W-1:0]     query_value,
    input  logic                          cfg_wr_en,
    input  logic [plc_pkg::CFG_W-1:0]     cfg_wr_data,
    output logic                          q_valid,
    output plc_pkg::item_t                q_item,
    input  logic                          q_pop
);

    logic [plc_pkg::CFG_W-1:0]       entries_reg;
    plc_pkg::item_t                  fifo_mem [plc_pkg::FIFO_DEPTH];
    logic [plc_pkg::FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [plc_pkg::FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [plc_pkg::FIFO_CNT_W-1:0]  cnt_reg, cnt_next;
    plc_pkg::item_t                  item;
    logic                            push;
    logic                            pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            entries_reg <= cfg_wr_data;
        end
    end

    // classify
    always_comb
    begin
        item.op    = kind ? plc_pkg::OP_QUERY : plc_pkg::OP_WRITE;
        item.wr_en = 32'(entry_index) < plc_pkg::TABLE_DEPTH;
        item.addr  = plc_pkg::IDX_W'(entry_index);
        item.key   = entry_key;
        item.value = entry_value;
        item.query = query_value;
        if (32'(entries_reg) > plc_pkg::TABLE_DEPTH)
        begin
            item.count = plc_pkg::CNT_W'(plc_pkg::TABLE_DEPTH);
        end
        else
        begin
            item.count = plc_pkg::CNT_W'(entries_reg);
        end
    end

    assign in_ready = cnt_reg != plc_pkg::FIFO_CNT_W'(plc_pkg::FIFO_DEPTH);
    assign q_valid  = cnt_reg != '0;
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;
    assign q_item   = fifo_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            if (32'(wr_ptr_reg) == plc_pkg::FIFO_DEPTH - 1)
            begin
                wr_ptr_next = '0;
            end
            else
            begin
                wr_ptr_next = wr_ptr_reg + plc_pkg::FIFO_PTR_W'(1);
            end
        end
        if (pop)
        begin
            if (32'(rd_ptr_reg) == plc_pkg::FIFO_DEPTH - 1)
            begin
                rd_ptr_next = '0;
            end
            else
            begin
                rd_ptr_next = rd_ptr_reg + plc_pkg::FIFO_PTR_W'(1);
            end
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + plc_pkg::FIFO_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - plc_pkg::FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= item;
        end
    end

endmodule

@@ src/plc_divider.sv @@
// Iterative unsigned divider, two restoring steps per cycle.
// Depends on plc_pkg (widths and request/response types).
module plc_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  plc_pkg::div_req_t req,
    output plc_pkg::div_rsp_t rsp
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [plc_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [plc_pkg::DIV_W-1:0]       quo_reg, quo_next;
    logic [plc_pkg::KEY_W-1:0]       rem_reg, rem_next;
    logic [plc_pkg::KEY_W-1:0]       den_reg, den_next;

    logic [plc_pkg::KEY_W:0]         p1, p2;
    logic                            ge1, ge2;
    logic [plc_pkg::KEY_W-1:0]       r1, r2;
    logic [plc_pkg::DIV_W-1:0]       q1, q2;

    always_comb
    begin
        p1  = {rem_reg, quo_reg[plc_pkg::DIV_W-1]};
        ge1 = p1 >= {1'b0, den_reg};
        r1  = ge1 ? plc_pkg::KEY_W'(p1 - {1'b0, den_reg}) : p1[plc_pkg::KEY_W-1:0];
        q1  = {quo_reg[plc_pkg::DIV_W-2:0], ge1};
        p2  = {r1, q1[plc_pkg::DIV_W-1]};
        ge2 = p2 >= {1'b0, den_reg};
        r2  = ge2 ? plc_pkg::KEY_W'(p2 - {1'b0, den_reg}) : p2[plc_pkg::KEY_W-1:0];
        q2  = {q1[plc_pkg::DIV_W-2:0], ge2};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = plc_pkg::DIV_CNT_W'(plc_pkg::DIV_STEPS);
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            quo_next = q2;
            rem_next = r2;
            cnt_next = cnt_reg - plc_pkg::DIV_CNT_W'(1);
            if (cnt_reg == plc_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

@@ src/plc_back.sv @@
// Back end: calibration table, bracket scan, interpolation sequencer, result register.
// Depends on plc_pkg; drives the plc_divider.
module plc_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    input  plc_pkg::item_t                     q_item,
    output logic                               q_pop,
    output plc_pkg::div_req_t                  div_req,
    input  plc_pkg::div_rsp_t                  div_rsp,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [plc_pkg::OUT_W-1:0]   interpolated,
    output logic [plc_pkg::STAT_W-1:0]         status
);

    plc_pkg::back_state_t state_reg, state_next;

    logic [plc_pkg::KEY_W-1:0]        key_mem [plc_pkg::TABLE_DEPTH];
    logic [plc_pkg::VAL_W-1:0]        val_mem [plc_pkg::TABLE_DEPTH];
    logic [plc_pkg::KEY_W-1:0]        rd_key_reg;
    logic [plc_pkg::VAL_W-1:0]        rd_val_reg;
    logic                             mem_we;

    logic [plc_pkg::CNT_W-1:0]        idx_reg, idx_next;
    logic [plc_pkg::CNT_W-1:0]        n_reg, n_next;
    logic [plc_pkg::KEY_W-1:0]        query_reg, query_next;
    logic [plc_pkg::KEY_W-1:0]        klo_reg, klo_next, khi_reg, khi_next;
    logic [plc_pkg::VAL_W-1:0]        vlo_reg, vlo_next, vhi_reg, vhi_next;
    logic signed [plc_pkg::KEY_W:0]   dv_reg, dv_next, dq_reg, dq_next, dk_reg, dk_next;
    logic signed [plc_pkg::DIV_W-1:0] prod_reg, prod_next;
    logic                             neg_reg, neg_next;
    logic [plc_pkg::KEY_W-1:0]        den_reg, den_next;
    logic signed [plc_pkg::DIV_W:0]   qfl_reg, qfl_next, qr_reg, qr_next;
    logic [plc_pkg::KEY_W-1:0]        rr_reg, rr_next;
    logic [plc_pkg::STAT_W-1:0]       res_reg, res_next;

    logic                             out_valid_reg, out_valid_next;
    logic signed [plc_pkg::OUT_W-1:0] out_interp_reg, out_interp_next;
    logic [plc_pkg::STAT_W-1:0]       out_status_reg, out_status_next;

    logic                             hit;
    logic                             last;
    logic                             prod_neg;
    logic [plc_pkg::DIV_W-1:0]        prod_mag;
    logic [plc_pkg::KEY_W:0]          twice_r;
    logic                             round_up;
    logic signed [plc_pkg::SUM_W-1:0] y_sum;
    logic                             in_range;
    logic signed [plc_pkg::OUT_W-1:0] y_sat;
    logic                             slot_free;

    assign hit       = rd_key_reg > query_reg;
    assign last      = idx_reg == n_reg - plc_pkg::CNT_W'(1);
    assign slot_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            plc_pkg::BS_IDLE:
            begin
                if (q_valid && q_item.op == plc_pkg::OP_QUERY)
                begin
                    if (q_item.count == '0)
                    begin
                        state_next = plc_pkg::BS_OUT;
                    end
                    else
                    begin
                        state_next = plc_pkg::BS_READ;
                    end
                end
            end
            plc_pkg::BS_READ:
            begin
                state_next = plc_pkg::BS_CMP;
            end
            plc_pkg::BS_CMP:
            begin
                if (hit)
                begin
                    state_next = plc_pkg::BS_CALC;
                end
                else if (last)
                begin
                    if (n_reg < plc_pkg::CNT_W'(2))
                    begin
                        state_next = plc_pkg::BS_OUT;
                    end
                    else
                    begin
                        state_next = plc_pkg::BS_CALC;
                    end
                end
                else
                begin
                    state_next = plc_pkg::BS_READ;
                end
            end
            plc_pkg::BS_CALC:
            begin
                if (khi_reg == klo_reg)
                begin
                    state_next = plc_pkg::BS_OUT;
                end
                else
                begin
                    state_next = plc_pkg::BS_MUL;
                end
            end
            plc_pkg::BS_MUL:
            begin
                state_next = plc_pkg::BS_DIVS;
            end
            plc_pkg::BS_DIVS:
            begin
                state_next = plc_pkg::BS_DIVW;
            end
            plc_pkg::BS_DIVW:
            begin
                if (div_rsp.done)
                begin
                    state_next = plc_pkg::BS_ROUND1;
                end
            end
            plc_pkg::BS_ROUND1:
            begin
                state_next = plc_pkg::BS_ROUND2;
            end
            plc_pkg::BS_ROUND2:
            begin
                state_next = plc_pkg::BS_OUT;
            end
            plc_pkg::BS_OUT:
            begin
                if (slot_free)
                begin
                    state_next = plc_pkg::BS_IDLE;
                end
            end
            default:
            begin
                state_next = plc_pkg::BS_IDLE;
            end
        endcase
    end

    // datapath arithmetic
    always_comb
    begin
        prod_neg = prod_reg[plc_pkg::DIV_W-1];
        prod_mag = prod_neg ? plc_pkg::DIV_W'(-prod_reg) : plc_pkg::DIV_W'(prod_reg);
        twice_r  = {rr_reg, 1'b0};
        round_up = (twice_r > {1'b0, den_reg}) || ((twice_r == {1'b0, den_reg}) && qfl_reg[0]);
        y_sum    = plc_pkg::SUM_W'(qr_reg)
                 + $signed({{(plc_pkg::SUM_W - plc_pkg::VAL_W){1'b0}}, vlo_reg});
        in_range = (&y_sum[plc_pkg::SUM_W-1:plc_pkg::OUT_W-1])
                || !(|y_sum[plc_pkg::SUM_W-1:plc_pkg::OUT_W-1]);
        if (in_range)
        begin
            y_sat = y_sum[plc_pkg::OUT_W-1:0];
        end
        else if (y_sum[plc_pkg::SUM_W-1])
        begin
            y_sat = {1'b1, {(plc_pkg::OUT_W-1){1'b0}}};
        end
        else
        begin
            y_sat = {1'b0, {(plc_pkg::OUT_W-1){1'b1}}};
        end
    end

    // register updates and outputs
    always_comb
    begin
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        div_req.start   = 1'b0;
        div_req.num     = prod_mag;
        div_req.den     = dk_reg[plc_pkg::KEY_W] ? plc_pkg::KEY_W'(-dk_reg)
                                                 : dk_reg[plc_pkg::KEY_W-1:0];
        idx_next        = idx_reg;
        n_next          = n_reg;
        query_next      = query_reg;
        klo_next        = klo_reg;
        vlo_next        = vlo_reg;
        khi_next        = khi_reg;
        vhi_next        = vhi_reg;
        dv_next         = dv_reg;
        dq_next         = dq_reg;
        dk_next         = dk_reg;
        prod_next       = prod_reg;
        neg_next        = neg_reg;
        den_next        = den_reg;
        qfl_next        = qfl_reg;
        rr_next         = rr_reg;
        qr_next         = qr_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_interp_next = out_interp_reg;
        out_status_next = out_status_reg;
        unique case (state_reg)
            plc_pkg::BS_IDLE:
            begin
                q_pop      = q_valid;
                mem_we     = q_valid && q_item.op == plc_pkg::OP_WRITE && q_item.wr_en;
                idx_next   = '0;
                n_next     = q_item.count;
                query_next = q_item.query;
                klo_next   = '0;
                vlo_next   = '0;
                res_next   = (q_item.count == '0) ? plc_pkg::STATUS_FEW : plc_pkg::STATUS_OK;
            end
            plc_pkg::BS_READ:
            begin
            end
            plc_pkg::BS_CMP:
            begin
                if (hit || last)
                begin
                    khi_next = rd_key_reg;
                    vhi_next = rd_val_reg;
                    if (!hit && n_reg < plc_pkg::CNT_W'(2))
                    begin
                        res_next = plc_pkg::STATUS_FEW;
                    end
                end
                else
                begin
                    klo_next = rd_key_reg;
                    vlo_next = rd_val_reg;
                    idx_next = idx_reg + plc_pkg::CNT_W'(1);
                end
            end
            plc_pkg::BS_CALC:
            begin
                dv_next = $signed({1'b0, vhi_reg}) - $signed({1'b0, vlo_reg});
                dq_next = $signed({1'b0, query_reg}) - $signed({1'b0, klo_reg});
                dk_next = $signed({1'b0, khi_reg}) - $signed({1'b0, klo_reg});
                if (khi_reg == klo_reg)
                begin
                    res_next = plc_pkg::STATUS_EQUAL;
                end
            end
            plc_pkg::BS_MUL:
            begin
                prod_next = dv_reg * dq_reg;
            end
            plc_pkg::BS_DIVS:
            begin
                div_req.start = 1'b1;
                neg_next      = (prod_neg ^ dk_reg[plc_pkg::KEY_W]) && (prod_reg != '0);
                den_next      = div_req.den;
            end
            plc_pkg::BS_DIVW:
            begin
            end
            plc_pkg::BS_ROUND1:
            begin
                // floor quotient and non-negative remainder
                if (neg_reg && div_rsp.rem != '0)
                begin
                    qfl_next = -$signed({1'b0, div_rsp.quo}) - (plc_pkg::DIV_W + 1)'(1);
                    rr_next  = den_reg - div_rsp.rem;
                end
                else if (neg_reg)
                begin
                    qfl_next = -$signed({1'b0, div_rsp.quo});
                    rr_next  = '0;
                end
                else
                begin
                    qfl_next = $signed({1'b0, div_rsp.quo});
                    rr_next  = div_rsp.rem;
                end
            end
            plc_pkg::BS_ROUND2:
            begin
                qr_next = qfl_reg + $signed({{plc_pkg::DIV_W{1'b0}}, round_up});
            end
            plc_pkg::BS_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_reg;
                    out_interp_next = (res_reg == plc_pkg::STATUS_OK) ? y_sat : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[q_item.addr] <= q_item.key;
            val_mem[q_item.addr] <= q_item.value;
        end
        rd_key_reg <= key_mem[idx_reg[plc_pkg::IDX_W-1:0]];
        rd_val_reg <= val_mem[idx_reg[plc_pkg::IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= plc_pkg::BS_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        n_reg          <= n_next;
        query_reg      <= query_next;
        klo_reg        <= klo_next;
        vlo_reg        <= vlo_next;
        khi_reg        <= khi_next;
        vhi_reg        <= vhi_next;
        dv_reg         <= dv_next;
        dq_reg         <= dq_next;
        dk_reg         <= dk_next;
        prod_reg       <= prod_next;
        neg_reg        <= neg_next;
        den_reg        <= den_next;
        qfl_reg        <= qfl_next;
        rr_reg         <= rr_next;
        qr_reg         <= qr_next;
        res_reg        <= res_next;
        out_interp_reg <= out_interp_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid    = out_valid_reg;
    assign interpolated = out_interp_reg;
    assign status       = out_status_reg;

endmodule

@@ src/piecewise_linear_calibration_lookup_top.sv @@
// Top level of the piecewise-linear calibration lookup.
// Instantiates plc_front, plc_back and plc_divider; uses plc_pkg and the defines header.
//
// Input channel (in_valid/in_ready): kind 0 writes entry_key/entry_value at
// entry_index and gives no result; kind 1 converts query_value.
// Output channel (out_valid/out_ready): one interpolated/status result per query.
// cfg_wr_en/cfg_wr_data set entries_in_use; write it only while the block is idle.
// A two-deep request queue sits ahead of the back end, so requests are taken
// while a query is still being worked on.
// Write: stored in the table at the edge it leaves the queue.
// Query: from leaving the queue to the result register, the back end scans up to
// 16 table entries in turn (read, then compare), then computes the differences,
// multiplies, divides, rounds and saturates; the 34-bit divide retires two bits
// a cycle. Queries are worked on one at a time.
// Reset clears the queue, the result valid flag and entries_in_use; table contents
// are undefined until written. If the receiver stalls, the result is held in its
// register and the back end waits once the next result is ready.
`include "piecewise_linear_calibration_lookup_top_defines.svh"

module piecewise_linear_calibration_lookup_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               kind,
    input  logic [plc_pkg::EIDX_W-1:0]         entry_index,
    input  logic [plc_pkg::KEY_W-1:0]          entry_key,
    input  logic [plc_pkg::VAL_W-1:0]          entry_value,
    input  logic [plc_pkg::KEY_W-1:0]          query_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [plc_pkg::OUT_W-1:0]   interpolated,
    output logic [plc_pkg::STAT_W-1:0]         status,
    input  logic                               cfg_wr_en,
    input  logic [plc_pkg::CFG_W-1:0]          cfg_wr_data
);

    logic               q_valid;
    logic               q_pop;
    plc_pkg::item_t     q_item;
    plc_pkg::div_req_t  div_req;
    plc_pkg::div_rsp_t  div_rsp;

    plc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .entry_index (entry_index),
        .entry_key   (entry_key),
        .entry_value (entry_value),
        .query_value (query_value),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    plc_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    plc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .div_req      (div_req),
        .div_rsp      (div_rsp),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .interpolated (interpolated),
        .status       (status)
    );

    `PLC_ASSERT_IMPLY(a_status_code, out_valid, status <= plc_pkg::STATUS_EQUAL)
    `PLC_ASSERT_IMPLY(a_flagged_zero, out_valid && status != plc_pkg::STATUS_OK, interpolated == '0)
    `PLC_ASSERT_IMPLY(a_empty_ready, !q_valid, in_ready)
    `PLC_ASSERT_NEXT(a_div_result_used, div_rsp.done, !div_rsp.done)

endmodule

@@ tb/sv/piecewise_linear_calibration_lookup_top_tb.sv @@
// Self-checking testbench for piecewise_linear_calibration_lookup_top: table loads,
// interpolation queries and entries_in_use settings checked against an in-bench predictor.
// Depends on plc_pkg and the block's RTL.
module piecewise_linear_calibration_lookup_top_tb;

    localparam int     DRAIN_CYCLES   = 100;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     ITEM_TARGET    = 1950;
    localparam int     HOLD_CYCLES    = 300;
    localparam longint SAT_HI         = (longint'(1) <<< (plc_pkg::OUT_W - 1)) - 1;
    localparam longint SAT_LO         = -(longint'(1) <<< (plc_pkg::OUT_W - 1));

    typedef struct {
        plc_pkg::op_t                op;
        logic [plc_pkg::EIDX_W-1:0]  index;
        logic [plc_pkg::KEY_W-1:0]   key;
        logic [plc_pkg::VAL_W-1:0]   value;
        logic [plc_pkg::KEY_W-1:0]   query;
    } lookup_req_t;

    typedef struct {
        logic [plc_pkg::OUT_W-1:0]   value;
        logic [plc_pkg::STAT_W-1:0]  status;
    } conversion_t;

    logic                              clk         = 1'b0;
    logic                              rst_n       = 1'b0;
    logic                              in_valid    = 1'b0;
    logic                              in_ready;
    logic                              kind        = 1'b0;
    logic [plc_pkg::EIDX_W-1:0]        entry_index = '0;
    logic [plc_pkg::KEY_W-1:0]         entry_key   = '0;
    logic [plc_pkg::VAL_W-1:0]         entry_value = '0;
    logic [plc_pkg::KEY_W-1:0]         query_value = '0;
    logic                              out_valid;
    logic                              out_ready   = 1'b0;
    logic signed [plc_pkg::OUT_W-1:0]  interpolated;
    logic [plc_pkg::STAT_W-1:0]        status;
    logic                              cfg_wr_en   = 1'b0;
    logic [plc_pkg::CFG_W-1:0]         cfg_wr_data = '0;

    lookup_req_t      pending_requests[$];
    conversion_t      expected_conversions[$];
    lookup_req_t      next_req;
    conversion_t      oldest_conversion;

    // predictor state
    logic [plc_pkg::KEY_W-1:0] cal_keys   [plc_pkg::TABLE_DEPTH];
    logic [plc_pkg::VAL_W-1:0] cal_values [plc_pkg::TABLE_DEPTH];
    logic [plc_pkg::CFG_W-1:0] cal_count = '0;

    // keys as loaded by the stimulus, for aiming queries
    logic [plc_pkg::KEY_W-1:0] stim_keys  [plc_pkg::TABLE_DEPTH];

    int               mismatches   = 0;
    int               items_pushed = 0;
    int               burst_left   = 0;
    int               gap_left     = 0;
    int               hold_left    = 0;
    bit               hold_done    = 1'b0;
    int               results_seen = 0;
    int               idle_cycles  = 0;
    logic [6:0]       mode_cycles  = '0;
    logic [1:0]       ready_mode   = '0;

    piecewise_linear_calibration_lookup_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .entry_index  (entry_index),
        .entry_key    (entry_key),
        .entry_value  (entry_value),
        .query_value  (query_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .interpolated (interpolated),
        .status       (status),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic conversion_t convert_query(input logic [plc_pkg::KEY_W-1:0] q_in);
        conversion_t r;
        int          n;
        int          upper;
        int          i;
        bit          found;
        longint      q, klo, vlo, khi, vhi, num, den, quo, rem, y;
        r.value  = '0;
        r.status = plc_pkg::STATUS_OK;
        q        = q_in;
        n        = (cal_count > plc_pkg::TABLE_DEPTH) ? plc_pkg::TABLE_DEPTH : cal_count;
        found    = 1'b0;
        upper    = 0;
        for (i = 0; i < n; i++)
        begin
            if (!found && cal_keys[i] > q_in)
            begin
                found = 1'b1;
                upper = i;
            end
        end
        if (!found && n < 2)
        begin
            r.status = plc_pkg::STATUS_FEW;
            return r;
        end
        if (found)
        begin
            khi = cal_keys[upper];
            vhi = cal_values[upper];
            klo = (upper == 0) ? 0 : cal_keys[upper - 1];
            vlo = (upper == 0) ? 0 : cal_values[upper - 1];
        end
        else
        begin
            khi = cal_keys[n - 1];
            vhi = cal_values[n - 1];
            klo = cal_keys[n - 2];
            vlo = cal_values[n - 2];
        end
        if (khi == klo)
        begin
            r.status = plc_pkg::STATUS_EQUAL;
            return r;
        end
        num = (vhi - vlo) * (q - klo);
        den = khi - klo;
        if (den < 0)
        begin
            num = -num;
            den = -den;
        end
        quo = num / den;
        rem = num % den;
        if (rem < 0)
        begin
            quo = quo - 1;
            rem = rem + den;
        end
        // round half to even
        if (2 * rem > den || (2 * rem == den && (quo & 1) != 0))
            quo = quo + 1;
        y = quo + vlo;
        if (y > SAT_HI)
            y = SAT_HI;
        if (y < SAT_LO)
            y = SAT_LO;
        r.value = y[plc_pkg::OUT_W-1:0];
        return r;
    endfunction

    task automatic push_write(input int idx, input int key, input int value);
        lookup_req_t r;
        r.op          = plc_pkg::OP_WRITE;
        r.index       = idx[plc_pkg::EIDX_W-1:0];
        r.key         = key[plc_pkg::KEY_W-1:0];
        r.value       = value[plc_pkg::VAL_W-1:0];
        r.query       = plc_pkg::KEY_W'($urandom);
        stim_keys[idx] = r.key;
        pending_requests.insert(pending_requests.size(), r);
        items_pushed++;
    endtask

    task automatic push_query(input int q);
        lookup_req_t r;
        r.op    = plc_pkg::OP_QUERY;
        r.index = plc_pkg::EIDX_W'($urandom);
        r.key   = plc_pkg::KEY_W'($urandom);
        r.value = plc_pkg::VAL_W'($urandom);
        r.query = q[plc_pkg::KEY_W-1:0];
        pending_requests.insert(pending_requests.size(), r);
        items_pushed++;
    endtask

    task automatic drain();
        while (pending_requests.size() != 0 || in_valid || expected_conversions.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_entries(input int v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v[plc_pkg::CFG_W-1:0];
        cal_count    = v[plc_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        @(negedge clk);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            kind        <= plc_pkg::OP_WRITE;
            entry_index <= '0;
            entry_key   <= '0;
            entry_value <= '0;
            query_value <= '0;
            burst_left  <= 0;
            gap_left    <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
            begin
                if (kind == plc_pkg::OP_WRITE)
                begin
                    cal_keys[entry_index]   = entry_key;
                    cal_values[entry_index] = entry_value;
                end
                else
                    expected_conversions.insert(expected_conversions.size(),
                        convert_query(query_value));
            end
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_requests.size() != 0)
            begin
                next_req = pending_requests.pop_front();
                in_valid    <= 1'b1;
                kind        <= next_req.op;
                entry_index <= next_req.index;
                entry_key   <= next_req.key;
                entry_value <= next_req.value;
                query_value <= next_req.query;
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(0, 23);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready    <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
            results_seen <= 0;
            mode_cycles  <= '0;
            ready_mode   <= '0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_conversions.size() == 0)
                    report_mismatch("result with no query outstanding");
                else
                begin
                    oldest_conversion = expected_conversions.pop_front();
                    if (interpolated !== oldest_conversion.value)
                        report_mismatch($sformatf("interpolated %0d, expected %0d",
                            interpolated, $signed(oldest_conversion.value)));
                    if (status !== oldest_conversion.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                            status, oldest_conversion.status));
                end
            end
            mode_cycles <= mode_cycles + 1'b1;
            if (mode_cycles == '1)
                ready_mode <= 2'($urandom_range(0, 3));
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (!hold_done && results_seen >= 300 && pending_requests.size() > 16)
            begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
                out_ready <= 1'b0;
            end
            else
            begin
                case (ready_mode)
                    2'd0: out_ready <= 1'b1;
                    2'd1: out_ready <= 1'($urandom_range(0, 1));
                    2'd2: out_ready <= (mode_cycles[1:0] == 2'd0);
                    default: out_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int          phase;
        int          i;
        int          k;
        int          nq;
        int          sel;
        int          step;
        int          acc;
        int          vacc;
        int          vmode;
        int          near;
        int          count_extremes[7];
        count_extremes = '{16, 31, 17, 0, 1, 2, 15};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // nothing in use; then a lone entry
        set_entries(0);
        push_query(0);
        push_write(0, 2, 3);
        drain();

        set_entries(1);
        push_query(0);
        push_query(1);          // half-way tie rounds up to even
        push_query(2);          // single entry not above query
        push_query(16'hFFFF);
        push_write(1, 2, 0);
        drain();

        set_entries(2);
        push_query(5);          // equal keys at extrapolation
        push_query(1);
        push_write(0, 0, 16'hFFFF);
        push_write(1, 1, 0);
        push_query(16'hFFFF);   // saturates low
        push_write(0, 0, 0);
        push_write(1, 1, 16'hFFFF);
        push_query(16'hFFFF);   // saturates high
        push_write(0, 0, 1);
        push_write(1, 2, 0);
        push_query(1);          // negative half rounds to even
        push_query(3);
        push_write(0, 100, 10);
        push_write(1, 50, 20);  // descending keys
        push_query(60);
        push_query(200);
        drain();

        phase = 0;
        while (items_pushed < ITEM_TARGET)
        begin
            set_entries(phase < 7 ? count_extremes[phase] : $urandom_range(0, 31));
            sel = $urandom_range(0, 9);
            if (phase == 0 || sel < 6)
            begin
                case ($urandom_range(0, 3))
                    0: step = 1;
                    1: step = 300;
                    2: step = 4095;
                    default: step = 8000;
                endcase
                vmode = $urandom_range(0, 3);
                acc   = $urandom_range(0, step);
                vacc  = (vmode == 3) ? 65535 : $urandom_range(0, 2000);
                for (i = 0; i < plc_pkg::TABLE_DEPTH; i++)
                begin
                    if (acc > 65535)
                        acc = 65535;
                    case (vmode)
                        0: push_write(i, acc, $urandom_range(0, 65535));
                        1: push_write(i, acc, vacc);
                        2: push_write(i, acc, $urandom_range(0, 1) ? 65535 : 0);
                        default: push_write(i, acc, vacc);
                    endcase
                    acc = acc + $urandom_range(0, step);
                    if (vmode == 1)
                        vacc = (vacc + $urandom_range(0, 4000) > 65535) ? 65535
                             : vacc + $urandom_range(0, 4000);
                    if (vmode == 3)
                        vacc = (vacc < 4000) ? 0 : vacc - $urandom_range(0, 4000);
                end
            end
            else
            begin
                nq = $urandom_range(1, 4);
                for (i = 0; i < nq; i++)
                    push_write($urandom_range(0, 15), $urandom_range(0, 65535),
                               $urandom_range(0, 65535));
            end
            nq = $urandom_range(20, 60);
            for (k = 0; k < nq; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    push_write($urandom_range(0, 15), $urandom_range(0, 65535),
                               $urandom_range(0, 65535));
                sel = $urandom_range(0, 9);
                if (sel < 4)
                    push_query($urandom_range(0, 65535));
                else if (sel < 8)
                begin
                    near = int'(stim_keys[$urandom_range(0, 15)]) + int'($urandom_range(0, 4)) - 2;
                    push_query(near < 0 ? 0 : (near > 65535 ? 65535 : near));
                end
                else
                    push_query(sel == 8 ? 0 : 65535);
            end
            drain();
            phase++;
        end

        drain();
        if (expected_conversions.size() != 0)
            report_mismatch($sformatf("%0d conversions never returned",
                expected_conversions.size()));
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
